### src/efsd_pkg.sv
`timescale 1ns / 1ps

package efsd_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

    localparam int WIN_W  = 4;
    localparam int T_W    = 24;
    localparam int SVC_W  = 16;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int NW_W   = 5;
    localparam int CFG_W  = 16;
    localparam int CFG_AW = 1;

    localparam int IN_W      = 40;
    localparam int OUT_USED  = WIN_W + 4 * T_W + 2 * CNT_W + SUM_W;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;
    localparam int OUT_PAD   = OUT_W - OUT_USED;

    localparam logic [CFG_AW-1:0] REG_NUM_WINDOWS = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_MAX_SERVICE = CFG_AW'(1);

    localparam logic [NW_W-1:0]  NUM_WINDOWS_RST = NW_W'(1);
    localparam logic [SVC_W-1:0] MAX_SERVICE_RST = SVC_W'(60);

    localparam logic [T_W-1:0]   T_MAX   = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // control into the shared compare unit
    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

    // compare unit status back to the sequencer
    typedef struct packed {
        logic             hit;
        logic             found;
        logic [IDX_W-1:0] chosen;
        logic [T_W-1:0]   best;
    } scan_res_t;

    // running statistics after the current job
    typedef struct packed {
        logic [CNT_W-1:0] jobs_served;
        logic [SUM_W-1:0] total_wait;
        logic [T_W-1:0]   max_wait_seen;
        logic [T_W-1:0]   latest_finish;
    } stats_t;

endpackage

### src/earliest_free_server_dispatch.sv
`timescale 1ns / 1ps

// channel   direction  width  contents
// s_axis    in         40     job word: arrival_time, service_time
// m_axis    out        168    result word: assignment and running statistics
// cfg       in         16     register write: num_windows, max_service
//
// for each job, from accept to the next accept, the shared compare unit looks at one window
// free time per cycle over the windows in use and stops at the first free window,
// then the CALC state forms wait and finish and the COMMIT state commits.
// reset clears all window free times, counts and statistics at once.
// a finished word waits in the output register; the next job is taken meanwhile
// and only its commit cycle holds while m_axis_tready is low.

module earliest_free_server_dispatch (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [23:0] arrival_time, [39:24] service_time
    input  logic [efsd_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] window_index, [27:4] wait_time, [51:28] finish_time,
    // [67:52] window_served, [83:68] jobs_served, [115:84] total_wait,
    // [139:116] max_wait_seen, [163:140] latest_finish, [167:164] zero
    output logic [efsd_pkg::OUT_W-1:0]    m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [efsd_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [efsd_pkg::CFG_W-1:0]    cfg_data
);
    import efsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_COMMIT
    } state_t;

    state_t           state_reg;
    logic [T_W-1:0]   arrival_reg;
    logic [SVC_W-1:0] svc_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [T_W-1:0]   wait_reg;
    logic [T_W-1:0]   fin_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [NW_W-1:0]  num_windows_reg;
    logic [SVC_W-1:0] max_service_reg;

    logic             accept;
    logic             commit;
    logic [SVC_W-1:0] svc_in;
    logic [SVC_W-1:0] svc_clamped;
    logic [IDX_W-1:0] last_idx_next;
    logic [T_W-1:0]   start_time;
    logic [T_W-1:0]   wait_next;
    logic [T_W:0]     fin_ext;
    logic [T_W-1:0]   fin_next;
    logic [T_W-1:0]   rd_free;
    logic [CNT_W-1:0] cnt_next;
    scan_ctl_t        scan_ctl;
    scan_res_t        scan_res;
    stats_t           stats_next;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign commit        = (state_reg == ST_COMMIT) && (!out_valid_reg || m_axis_tready);

    assign svc_in      = s_axis_tdata[T_W +: SVC_W];
    assign svc_clamped = (svc_in > max_service_reg) ? max_service_reg : svc_in;

    // zero windows acts as one, too many saturates
    always_comb
    begin
        if (num_windows_reg == '0)
        begin
            last_idx_next = '0;
        end
        else if (32'(num_windows_reg) > MAX_WINDOWS)
        begin
            last_idx_next = IDX_W'(MAX_WINDOWS - 1);
        end
        else
        begin
            last_idx_next = IDX_W'(num_windows_reg - NW_W'(1));
        end
    end

    assign start_time = scan_res.found ? arrival_reg : scan_res.best;
    assign wait_next  = scan_res.found ? '0 : scan_res.best - arrival_reg;
    assign fin_ext    = {1'b0, start_time} + (T_W + 1)'(svc_reg);
    assign fin_next   = fin_ext[T_W] ? T_MAX : fin_ext[T_W-1:0];

    assign scan_ctl.start = accept;
    assign scan_ctl.step  = (state_reg == ST_SCAN);

    efsd_window_bank u_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_free  (rd_free),
        .wr_en    (commit),
        .wr_idx   (scan_res.chosen),
        .wr_free  (fin_reg),
        .cnt_next (cnt_next)
    );

    efsd_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .idx     (idx_reg),
        .arrival (arrival_reg),
        .free_at (rd_free),
        .res     (scan_res)
    );

    efsd_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .wait_in    (wait_reg),
        .fin_in     (fin_reg),
        .stats_next (stats_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_windows_reg <= NUM_WINDOWS_RST;
            max_service_reg <= MAX_SERVICE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NUM_WINDOWS: num_windows_reg <= cfg_data[NW_W-1:0];
                REG_MAX_SERVICE: max_service_reg <= cfg_data[SVC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            arrival_reg   <= '0;
            svc_reg       <= '0;
            last_idx_reg  <= '0;
            idx_reg       <= '0;
            wait_reg      <= '0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // a commit in the same cycle refills the output register
            if (m_axis_tvalid && m_axis_tready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        arrival_reg  <= s_axis_tdata[T_W-1:0];
                        svc_reg      <= svc_clamped;
                        last_idx_reg <= last_idx_next;
                        idx_reg      <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // stop at the first free window or after the last one in use
                    if (scan_res.hit || (idx_reg == last_idx_reg))
                    begin
                        state_reg <= ST_CALC;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_CALC:
                begin
                    wait_reg  <= wait_next;
                    fin_reg   <= fin_next;
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (commit)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {OUT_PAD'(0),
                                          stats_next.latest_finish,
                                          stats_next.max_wait_seen,
                                          stats_next.total_wait,
                                          stats_next.jobs_served,
                                          cnt_next,
                                          fin_reg,
                                          wait_reg,
                                          WIN_W'(scan_res.chosen)};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### src/efsd_window_bank.sv
`timescale 1ns / 1ps

module efsd_window_bank (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [efsd_pkg::IDX_W-1:0]  rd_idx,
    output logic [efsd_pkg::T_W-1:0]    rd_free,
    input  logic                        wr_en,
    input  logic [efsd_pkg::IDX_W-1:0]  wr_idx,
    input  logic [efsd_pkg::T_W-1:0]    wr_free,
    output logic [efsd_pkg::CNT_W-1:0]  cnt_next
);
    import efsd_pkg::*;

    logic [T_W-1:0]   free_reg  [MAX_WINDOWS];
    logic [CNT_W-1:0] count_reg [MAX_WINDOWS];

    assign rd_free  = free_reg[rd_idx];
    // saturating served count for the window being written
    assign cnt_next = (count_reg[wr_idx] == CNT_MAX) ? CNT_MAX
                                                     : count_reg[wr_idx] + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOWS; i++)
            begin
                free_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            free_reg[wr_idx]  <= wr_free;
            count_reg[wr_idx] <= cnt_next;
        end
    end

endmodule

### src/efsd_scan.sv
`timescale 1ns / 1ps

module efsd_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  efsd_pkg::scan_ctl_t         ctl,
    input  logic [efsd_pkg::IDX_W-1:0]  idx,
    input  logic [efsd_pkg::T_W-1:0]    arrival,
    input  logic [efsd_pkg::T_W-1:0]    free_at,
    output efsd_pkg::scan_res_t         res
);
    import efsd_pkg::*;

    logic             found_reg;
    logic [IDX_W-1:0] chosen_reg;
    logic [T_W-1:0]   best_reg;
    logic             hit;
    logic             better;

    assign hit    = arrival >= free_at;
    // the first window seeds the running minimum unless it is already free
    assign better = (idx == '0) || (free_at < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.step && hit)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            if (hit)
            begin
                chosen_reg <= idx;
            end
            else if (better)
            begin
                chosen_reg <= idx;
                best_reg   <= free_at;
            end
        end
    end

    assign res.hit    = hit;
    assign res.found  = found_reg;
    assign res.chosen = chosen_reg;
    assign res.best   = best_reg;

endmodule

### src/efsd_stats.sv
`timescale 1ns / 1ps

module efsd_stats (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      commit,
    input  logic [efsd_pkg::T_W-1:0]  wait_in,
    input  logic [efsd_pkg::T_W-1:0]  fin_in,
    output efsd_pkg::stats_t          stats_next
);
    import efsd_pkg::*;

    logic [CNT_W-1:0] jobs_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [T_W-1:0]   wait_peak_reg;
    logic [T_W-1:0]   fin_peak_reg;
    logic [SUM_W:0]   sum_ext;

    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(wait_in);

    always_comb
    begin
        stats_next.jobs_served   = (jobs_reg == CNT_MAX) ? CNT_MAX : jobs_reg + CNT_W'(1);
        stats_next.total_wait    = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        stats_next.max_wait_seen = (wait_in > wait_peak_reg) ? wait_in : wait_peak_reg;
        stats_next.latest_finish = (fin_in > fin_peak_reg) ? fin_in : fin_peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jobs_reg      <= '0;
            sum_reg       <= '0;
            wait_peak_reg <= '0;
            fin_peak_reg  <= '0;
        end
        else if (commit)
        begin
            jobs_reg      <= stats_next.jobs_served;
            sum_reg       <= stats_next.total_wait;
            wait_peak_reg <= stats_next.max_wait_seen;
            fin_peak_reg  <= stats_next.latest_finish;
        end
    end

endmodule

### src/efsd_checker.sv
`timescale 1ns / 1ps

module efsd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [efsd_pkg::OUT_W-1:0]    m_axis_tdata
);
    import efsd_pkg::*;

    logic [T_W-1:0]   wait_f;
    logic [T_W-1:0]   fin_f;
    logic [CNT_W-1:0] served_f;
    logic [CNT_W-1:0] jobs_f;
    logic [SUM_W-1:0] total_f;
    logic [T_W-1:0]   max_wait_f;
    logic [T_W-1:0]   latest_f;

    assign wait_f     = m_axis_tdata[27:4];
    assign fin_f      = m_axis_tdata[51:28];
    assign served_f   = m_axis_tdata[67:52];
    assign jobs_f     = m_axis_tdata[83:68];
    assign total_f    = m_axis_tdata[115:84];
    assign max_wait_f = m_axis_tdata[139:116];
    assign latest_f   = m_axis_tdata[163:140];

    // a job is worked on in the scan, calc and commit states before the next is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken on the cycle after an accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    a_peaks: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((max_wait_f >= wait_f) && (latest_f >= fin_f)
                           && (total_f >= SUM_W'(wait_f))))
        else $error("running statistics below the current job");

    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((served_f != '0) && (jobs_f != '0) && (jobs_f >= served_f)))
        else $error("served counts inconsistent");

endmodule

bind earliest_free_server_dispatch efsd_checker u_efsd_checker (.*);
